FILE: hdl/length_prefixed_message_fifo_defines.svh
// Assertion macros used by the message FIFO datapath.
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lpmf_pkg.sv
// Shared constants, types and pointer helpers for the message FIFO.
package lpmf_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int MAX_MESSAGE = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int USED_W      = 6;
    localparam int SUM_W       = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;

    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_STRAY  = 2'd2;

    typedef struct packed {
        logic accept;
        logic eval_len;
        logic stream;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic pop_needs_len;
        logic stream_done;
    } sts_t;

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] ptr,
                                                   input logic [SUM_W-1:0] n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(ptr) + n;
        if (s >= SUM_W'(STORE_DEPTH))
        begin
            s = s - SUM_W'(STORE_DEPTH);
        end
        return ADDR_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] used_of(input logic [ADDR_W-1:0] wp,
                                                  input logic [ADDR_W-1:0] rp);
        logic [SUM_W-1:0] s;
        if (wp >= rp)
        begin
            s = SUM_W'(wp) - SUM_W'(rp);
        end
        else
        begin
            s = SUM_W'(wp) + SUM_W'(STORE_DEPTH) - SUM_W'(rp);
        end
        return ADDR_W'(s);
    endfunction

endpackage

FILE: hdl/lpmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/lpmf_ctrl.sv
// Controller state machine: input acceptance, length fetch and pop streaming.
module lpmf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    input  lpmf_pkg::sts_t sts,
    output logic          s_ready,
    output lpmf_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LEN    = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        s_ready      = 1'b0;
        cmd          = '0;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready    = sts.out_free;
                cmd.accept = s_valid && sts.out_free;
                if (cmd.accept && sts.pop_needs_len)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                cmd.eval_len = 1'b1;
                state_next   = ST_STREAM;
            end
            ST_STREAM:
            begin
                cmd.stream = 1'b1;
                if (sts.stream_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/lpmf_datapath.sv
// Datapath: pointers, message bookkeeping, byte store and output register.
`include "length_prefixed_message_fifo_defines.svh"

module lpmf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpmf_pkg::cmd_t                cmd,
    output lpmf_pkg::sts_t                sts,
    input  logic [1:0]                    in_op,
    input  logic [lpmf_pkg::LEN_W-1:0]    in_len,
    input  logic [lpmf_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [1:0]                    out_kind,
    output logic [1:0]                    out_status,
    output logic [lpmf_pkg::BYTE_W-1:0]   out_data,
    output logic                          out_last,
    output logic [lpmf_pkg::USED_W-1:0]   out_used
);

    localparam int AW = lpmf_pkg::ADDR_W;
    localparam int LW = lpmf_pkg::LEN_W;
    localparam int SW = lpmf_pkg::SUM_W;
    localparam int BW = lpmf_pkg::BYTE_W;

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [LW-1:0] pending_reg, pending_next;
    logic [LW-1:0] total_reg, total_next;
    logic          rejecting_reg, rejecting_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [SW-1:0] remain_reg, remain_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          rd_last_reg, rd_last_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [BW-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic [lpmf_pkg::USED_W-1:0] out_used_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    logic [AW-1:0] used_now;
    logic [AW-1:0] used_after;
    logic          out_free;
    logic          load_out;
    logic          move;
    logic          issue;
    logic [BW-1:0] len_clamped;
    logic [SW-1:0] plen;

    assign used_now = lpmf_pkg::used_of(wp_reg, rp_reg);
    assign used_after = lpmf_pkg::used_of(wp_next, rp_next);
    assign out_free = !out_valid_reg || out_ready;
    assign move = cmd.stream && rd_valid_reg && out_free;
    assign issue = cmd.stream && (remain_reg != '0) && (!rd_valid_reg || move);

    assign len_clamped = (ram_rdata > BW'(lpmf_pkg::MAX_MESSAGE)) ?
                         BW'(lpmf_pkg::MAX_MESSAGE) : ram_rdata;

    always_comb
    begin
        plen = SW'(len_clamped);
        if (plen >= SW'(used_now))
        begin
            plen = SW'(used_now) - SW'(1);
        end
    end

    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        pending_next    = pending_reg;
        total_next      = total_reg;
        rejecting_next  = rejecting_reg;
        rd_addr_next    = rd_addr_reg;
        remain_next     = remain_reg;
        rd_valid_next   = rd_valid_reg;
        rd_last_next    = rd_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = BW'(in_len);
        ram_re          = 1'b0;
        ram_raddr       = rd_addr_reg;
        load_out        = 1'b0;
        out_kind_next   = lpmf_pkg::KIND_STATUS;
        out_status_next = lpmf_pkg::STAT_OK;
        out_data_next   = '0;
        out_last_next   = 1'b1;

        if (cmd.accept)
        begin
            unique case (in_op)
                lpmf_pkg::OP_BEGIN:
                begin
                    load_out       = 1'b1;
                    pending_next   = in_len;
                    rejecting_next = 1'b0;
                    if ((SW'(in_len) > SW'(lpmf_pkg::MAX_MESSAGE)) ||
                        (SW'(used_now) + SW'(in_len) >= SW'(lpmf_pkg::STORE_DEPTH - 1)))
                    begin
                        rejecting_next  = (in_len != '0);
                        out_status_next = lpmf_pkg::STAT_REJECT;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        total_next = in_len;
                        if (in_len == '0)
                        begin
                            wp_next = lpmf_pkg::wrap_add(wp_reg, SW'(1));
                        end
                    end
                end
                lpmf_pkg::OP_BYTE:
                begin
                    load_out = 1'b1;
                    if (pending_reg == '0)
                    begin
                        out_status_next = lpmf_pkg::STAT_STRAY;
                    end
                    else if (rejecting_reg)
                    begin
                        pending_next    = pending_reg - LW'(1);
                        rejecting_next  = (pending_reg != LW'(1));
                        out_status_next = lpmf_pkg::STAT_REJECT;
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = lpmf_pkg::wrap_add(wp_reg,
                                       SW'(total_reg) - SW'(pending_reg) + SW'(1));
                        ram_wdata    = in_byte;
                        pending_next = pending_reg - LW'(1);
                        if (pending_reg == LW'(1))
                        begin
                            wp_next = lpmf_pkg::wrap_add(wp_reg, SW'(total_reg) + SW'(1));
                        end
                    end
                end
                lpmf_pkg::OP_REQUEST:
                begin
                    if (used_now == '0)
                    begin
                        load_out      = 1'b1;
                        out_kind_next = lpmf_pkg::KIND_EMPTY;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = rp_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.eval_len)
        begin
            rp_next       = lpmf_pkg::wrap_add(rp_reg, plen + SW'(1));
            rd_addr_next  = lpmf_pkg::wrap_add(rp_reg, SW'(1));
            remain_next   = plen;
            rd_valid_next = 1'b0;
            if (plen == '0)
            begin
                load_out      = 1'b1;
                out_kind_next = lpmf_pkg::KIND_EMPTY;
            end
        end

        if (move)
        begin
            load_out      = 1'b1;
            out_kind_next = lpmf_pkg::KIND_BYTE;
            out_data_next = ram_rdata;
            out_last_next = rd_last_reg;
            rd_valid_next = 1'b0;
        end

        if (issue)
        begin
            ram_re        = 1'b1;
            ram_raddr     = rd_addr_reg;
            rd_addr_next  = lpmf_pkg::wrap_add(rd_addr_reg, SW'(1));
            remain_next   = remain_reg - SW'(1);
            rd_valid_next = 1'b1;
            rd_last_next  = (remain_reg == SW'(1));
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    lpmf_ram #(
        .WIDTH(BW),
        .DEPTH(lpmf_pkg::STORE_DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            pending_reg   <= '0;
            total_reg     <= '0;
            rejecting_reg <= 1'b0;
            rd_addr_reg   <= '0;
            remain_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            pending_reg   <= pending_next;
            total_reg     <= total_next;
            rejecting_reg <= rejecting_next;
            rd_addr_reg   <= rd_addr_next;
            remain_reg    <= remain_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
            out_used_reg   <= lpmf_pkg::USED_W'(used_after);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;
    assign out_used   = out_used_reg;

    assign sts.out_free      = out_free;
    assign sts.pop_needs_len = (in_op == lpmf_pkg::OP_REQUEST) && (used_now != '0);
    assign sts.stream_done   = (remain_reg == '0) && !rd_valid_reg;

    `LPMF_ASSERT_NOW(a_load_needs_room, load_out, out_free, "result loaded over a waiting beat")
    `LPMF_ASSERT_NOW(a_reject_counts, rejecting_reg, pending_reg != '0, "rejecting with nothing left")
    `LPMF_ASSERT_NOW(a_pending_in_range, !rejecting_reg, pending_reg <= total_reg,
                     "open message has more bytes pending than its length")
    `LPMF_ASSERT_NEXT(a_ptrs_hold_in_stream, cmd.stream, wp_reg == $past(wp_reg),
                      "write pointer moved during a pop")

endmodule

FILE: hdl/length_prefixed_message_fifo.sv
// Begin and payload beats: result in the cycle after acceptance, one beat per cycle
// while the output is free. Pop request: the length is read and evaluated, then bytes
// stream out one per cycle while the output is free, with the input held until the pop
// ends. An empty store answers in the cycle after acceptance, a zero-length message
// from the length state. Reset clears pointers, message counters and the output valid
// flag; the byte store itself is not cleared and only written entries are ever read.
module length_prefixed_message_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // msg_length[5:0], data_byte[13:6], zero pad
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status[1:0], pop_byte[9:2], used_bytes[15:10]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast
);

    lpmf_pkg::cmd_t cmd;
    lpmf_pkg::sts_t sts;

    logic [1:0]                          out_status;
    logic [lpmf_pkg::BYTE_W-1:0]         out_data;
    logic [lpmf_pkg::USED_W-1:0]         out_used;

    lpmf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_valid(s_axis_tvalid),
        .sts    (sts),
        .s_ready(s_axis_tready),
        .cmd    (cmd)
    );

    lpmf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_axis_tuser),
        .in_len    (s_axis_tdata[5:0]),
        .in_byte   (s_axis_tdata[13:6]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (m_axis_tuser),
        .out_status(out_status),
        .out_data  (out_data),
        .out_last  (m_axis_tlast),
        .out_used  (out_used)
    );

    assign m_axis_tdata = {out_used, out_data, out_status};

endmodule
